/* sv/ecas_pkg.sv */
// Shared types, constants and helpers for the extended compare action scheduler.
`default_nettype none

package ecas_pkg;

	// Field and register widths.
	localparam int COUNT_BITS_DEF = 32;
	localparam int TICK_W         = 32;
	localparam int WINDOW_W       = 17;
	localparam int BACKDATE_W     = 14;
	localparam int CMP_W          = 16;
	localparam int APB_ADDR_W     = 3;
	localparam int APB_DATA_W     = 32;

	// Register values after reset.
	localparam logic [WINDOW_W-1:0]   WINDOW_RST   = 17'd32768;
	localparam logic [BACKDATE_W-1:0] BACKDATE_RST = 14'd1024;

	// Register indexes, taken from address bit 2.
	localparam logic REG_WINDOW   = 1'b0;
	localparam logic REG_BACKDATE = 1'b1;

	// Operation codes.
	localparam logic [1:0] OP_SCHEDULE  = 2'd0;
	localparam logic [1:0] OP_CANCEL    = 2'd1;
	localparam logic [1:0] OP_IRQ_EVENT = 2'd2;

	// Status codes as reported in a response.
	localparam logic [1:0] STATUS_IDLE   = 2'd0;
	localparam logic [1:0] STATUS_WAIT   = 2'd1;
	localparam logic [1:0] STATUS_ARMED  = 2'd2;
	localparam logic [1:0] STATUS_MISSED = 2'd3;

	// Scheduler state, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_WAIT   = 4'b0010,
		ST_ARMED  = 4'b0100,
		ST_MISSED = 4'b1000
	} sched_state_t;

	// One request item.
	typedef struct packed {
		logic [1:0]        operation;
		logic [TICK_W-1:0] now_ticks;
		logic [TICK_W-1:0] target_ticks;
		logic [TICK_W-1:0] origin_ticks;
		logic              origin_from_now;
		logic [1:0]        pin_action_req;
		logic              match_flag;
	} req_t;

	// One response item.
	typedef struct packed {
		logic [1:0]       status;
		logic             success;
		logic [1:0]       pin_action;
		logic [CMP_W-1:0] compare_value;
		logic             irq_enable;
		logic             notify;
	} rsp_t;

	// Map the one-hot state to its reported status code.
	function automatic logic [1:0] status_code(sched_state_t s);
		logic [1:0] code;
		unique case (s)
			ST_IDLE:   code = STATUS_IDLE;
			ST_WAIT:   code = STATUS_WAIT;
			ST_ARMED:  code = STATUS_ARMED;
			ST_MISSED: code = STATUS_MISSED;
			default:   code = STATUS_IDLE;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

/* sv/extended_compare_action_scheduler_unit.sv */
// Top level of the extended compare action scheduler: request register, scheduler, response register.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         req_valid / req_ready     req_data (req_t)
//   response  out        rsp_valid / rsp_ready     rsp_data (rsp_t)
//   config    in         APB psel/penable/pwrite   paddr, pwdata, prdata
//
// A request is registered on acceptance and handled once the response register is free, where one
// subtract-and-compare level updates the scheduler state and loads the response register.
// The response becomes valid when its request leaves the request register; one request is taken each
// cycle while responses are drained, limited only by the response register.
// A stalled response holds its register; the request register then holds one more request.
// Reset clears the scheduler state and both valid flags and loads the configuration defaults.
`default_nettype none

module extended_compare_action_scheduler_unit
	import ecas_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output      logic                  req_ready,
	input  wire req_t                  req_data,
	output      logic                  rsp_valid,
	input  wire logic                  rsp_ready,
	output      rsp_t                  rsp_data,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output      logic [APB_DATA_W-1:0] prdata,
	output      logic                  pready
);

	// Configuration registers.
	logic [WINDOW_W-1:0]   window_q;
	logic [BACKDATE_W-1:0] backdate_q;

	// Request stage and response register.
	req_t req_s1;
	logic req_valid_s1;
	rsp_t rsp_q;
	logic rsp_valid_q;

	// Scheduler state.
	sched_state_t          state_q;
	logic [COUNT_BITS-1:0] target_q;
	logic [COUNT_BITS-1:0] origin_q;
	logic [1:0]            wanted_q;
	logic [1:0]            saved_q;
	logic [1:0]            driven_q;
	logic [CMP_W-1:0]      compare_q;
	logic                  irq_q;

	// Next values.
	sched_state_t          state_d;
	logic [COUNT_BITS-1:0] target_d;
	logic [COUNT_BITS-1:0] origin_d;
	logic [1:0]            wanted_d;
	logic [1:0]            saved_d;
	logic [1:0]            driven_d;
	logic [CMP_W-1:0]      compare_d;
	logic                  irq_d;
	logic                  success_d;
	logic                  notify_d;

	// Arithmetic on the registered request.
	logic [COUNT_BITS-1:0] now_c;
	logic [COUNT_BITS-1:0] tgt_c;
	logic [COUNT_BITS-1:0] org_c;
	logic [COUNT_BITS-1:0] backdate_c;
	logic [COUNT_BITS-1:0] window_c;
	logic [COUNT_BITS-1:0] dist_new;
	logic [COUNT_BITS-1:0] dist_old;
	logic [COUNT_BITS-1:0] elapsed_new;
	logic [COUNT_BITS-1:0] span_new;
	logic                  past_new;
	logic                  past_old;
	logic                  in_win_new;
	logic                  in_win_old;
	logic                  advance;

	// The APB port never stalls; a write lands in the access cycle.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= WINDOW_RST;
			backdate_q <= BACKDATE_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_WINDOW:   window_q   <= pwdata[WINDOW_W-1:0];
				REG_BACKDATE: backdate_q <= pwdata[BACKDATE_W-1:0];
				default:      window_q   <= window_q;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (paddr[2])
			REG_WINDOW:   prdata = APB_DATA_W'(window_q);
			REG_BACKDATE: prdata = APB_DATA_W'(backdate_q);
			default:      prdata = '0;
		endcase
	end

	// Handshake: the request stage moves on when the response register is free.
	assign advance   = req_valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !req_valid_s1 || advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (req_ready) begin
				req_valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request payload register.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req_data;
		end
	end

	// Wrap-aware distances. With an origin taken from now, elapsed time is the
	// backdate itself and the span is the target distance plus the backdate.
	always_comb begin
		now_c       = COUNT_BITS'(req_s1.now_ticks);
		tgt_c       = COUNT_BITS'(req_s1.target_ticks);
		org_c       = COUNT_BITS'(req_s1.origin_ticks);
		backdate_c  = COUNT_BITS'(backdate_q);
		window_c    = COUNT_BITS'(window_q);
		dist_new    = tgt_c - now_c;
		dist_old    = target_q - now_c;
		elapsed_new = req_s1.origin_from_now ? backdate_c : now_c - org_c;
		span_new    = req_s1.origin_from_now ? dist_new + backdate_c : tgt_c - org_c;
		past_new    = elapsed_new > span_new;
		past_old    = (now_c - origin_q) > (target_q - origin_q);
		in_win_new  = dist_new < window_c;
		in_win_old  = dist_old < window_c;
	end

	// Scheduler decision for the request in the request stage.
	always_comb begin
		state_d   = state_q;
		target_d  = target_q;
		origin_d  = origin_q;
		wanted_d  = wanted_q;
		saved_d   = saved_q;
		driven_d  = driven_q;
		compare_d = compare_q;
		irq_d     = irq_q;
		success_d = 1'b0;
		notify_d  = 1'b0;
		unique case (req_s1.operation)
			OP_SCHEDULE: begin
				saved_d   = driven_q;
				target_d  = tgt_c;
				origin_d  = req_s1.origin_from_now ? now_c - backdate_c : org_c;
				wanted_d  = req_s1.pin_action_req;
				irq_d     = 1'b1;
				compare_d = req_s1.target_ticks[CMP_W-1:0];
				if (past_new && !req_s1.match_flag) begin
					// Missed: the driven action is left as it was.
					state_d  = ST_MISSED;
					notify_d = 1'b1;
				end else begin
					success_d = 1'b1;
					if (in_win_new) begin
						driven_d = req_s1.pin_action_req;
						state_d  = ST_ARMED;
					end else begin
						state_d = ST_WAIT;
					end
				end
			end
			OP_CANCEL: begin
				if (state_q == ST_WAIT) begin
					irq_d     = 1'b0;
					driven_d  = saved_q;
					state_d   = ST_IDLE;
					success_d = 1'b1;
				end else if (state_q == ST_ARMED) begin
					compare_d = req_s1.now_ticks[CMP_W-1:0] - CMP_W'(1);
					irq_d     = 1'b0;
					driven_d  = saved_q;
					state_d   = ST_IDLE;
					success_d = !req_s1.match_flag;
				end
			end
			OP_IRQ_EVENT: begin
				if (irq_q) begin
					if (past_old) begin
						irq_d    = 1'b0;
						state_d  = (state_q == ST_WAIT) ? ST_MISSED : ST_IDLE;
						notify_d = 1'b1;
					end else if (in_win_old) begin
						driven_d = wanted_q;
						state_d  = ST_ARMED;
					end else begin
						state_d = ST_WAIT;
					end
				end
			end
			default: begin
				state_d = state_q;
			end
		endcase
	end

	// Scheduler state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			target_q  <= '0;
			origin_q  <= '0;
			wanted_q  <= '0;
			saved_q   <= '0;
			driven_q  <= '0;
			compare_q <= '0;
			irq_q     <= 1'b0;
		end else if (advance) begin
			state_q   <= state_d;
			target_q  <= target_d;
			origin_q  <= origin_d;
			wanted_q  <= wanted_d;
			saved_q   <= saved_d;
			driven_q  <= driven_d;
			compare_q <= compare_d;
			irq_q     <= irq_d;
		end
	end

	// Response payload register.
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.status        <= status_code(state_d);
			rsp_q.success       <= success_d;
			rsp_q.pin_action    <= driven_d;
			rsp_q.compare_value <= compare_d;
			rsp_q.irq_enable    <= irq_d;
			rsp_q.notify        <= notify_d;
		end
	end

endmodule

`default_nettype wire

/* sv/ecas_checker.sv */
// Port-level checker for the extended compare action scheduler, bound to the top level.
`default_nettype none

module ecas_checker
	import ecas_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp_data
);

	// A stalled response keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	// A notification never comes with success.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.notify |-> !rsp_data.success)
		else $error("notify and success together");

	// While waiting or armed the compare interrupt is enabled.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.status == STATUS_WAIT || rsp_data.status == STATUS_ARMED)
		|-> rsp_data.irq_enable)
		else $error("pending action without interrupt enable");

	// A successful request never reports a missed status.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.success |-> rsp_data.status != STATUS_MISSED)
		else $error("success reported with missed status");

	// Without a stalled request in flight, the request side is ready.
	assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |=> req_ready || $past(req_valid && req_ready))
		else $error("request side stalled with empty response");

endmodule

bind extended_compare_action_scheduler_unit ecas_checker u_ecas_checker (.*);

`default_nettype wire

/* dv/extended_compare_action_scheduler_unit_tb.sv */
// Self-checking testbench for the extended compare action scheduler unit.
module extended_compare_action_scheduler_unit_tb;
	import ecas_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_PER_PHASE = 322;
	localparam int NUM_PHASES = 6;
	localparam int MAX_REPORTS = 40;

	// Operation code that the block must ignore.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Pin actions.
	localparam logic [1:0] ACT_DISCONNECT = 2'd0;
	localparam logic [1:0] ACT_TOGGLE     = 2'd1;
	localparam logic [1:0] ACT_CLEAR      = 2'd2;
	localparam logic [1:0] ACT_SET        = 2'd3;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	extended_compare_action_scheduler_unit uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Requests waiting to be driven and responses the scheduler should produce.
	req_t sched_requests_q[$];
	rsp_t sched_results_q[$];

	// Configuration as the predictor sees it.
	logic [WINDOW_W-1:0]   cfg_window   = WINDOW_RST;
	logic [BACKDATE_W-1:0] cfg_backdate = BACKDATE_RST;

	// Predicted scheduler state.
	logic [1:0]       p_state  = STATUS_IDLE;
	logic [31:0]      p_target = '0;
	logic [31:0]      p_origin = '0;
	logic [1:0]       p_want   = ACT_DISCONNECT;
	logic [1:0]       p_saved  = ACT_DISCONNECT;
	logic [1:0]       p_driven = ACT_DISCONNECT;
	logic [CMP_W-1:0] p_cmp    = '0;
	logic             p_irq    = 1'b0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit req_taken = 1'b0;
	int cycles = 0;
	int mismatches = 0;
	int n_requests = 0;
	int n_results = 0;
	int n_armed = 0;
	int n_missed = 0;
	int n_notify = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Wrap-aware test: now is past when it lies further from the origin than the target.
	function automatic logic target_passed(logic [31:0] now);
		logic [31:0] elapsed;
		logic [31:0] span;
		elapsed = now - p_origin;
		span = p_target - p_origin;
		return elapsed > span;
	endfunction

	// Arm the pin action when the target is inside the window, else keep waiting.
	function automatic void try_arm(logic [31:0] now);
		logic [31:0] gap;
		gap = p_target - now;
		if (gap < {15'b0, cfg_window}) begin
			p_driven = p_want;
			p_state = STATUS_ARMED;
		end else begin
			p_state = STATUS_WAIT;
		end
	endfunction

	// Update the predicted state for one request and return the response it causes.
	function automatic rsp_t compute_compare_response(req_t r);
		rsp_t res;
		logic ok;
		logic note;
		logic [31:0] dec;
		ok = 1'b0;
		note = 1'b0;
		case (r.operation)
			OP_SCHEDULE: begin
				p_saved = p_driven;
				p_origin = r.origin_from_now ? r.now_ticks - {18'b0, cfg_backdate}
					: r.origin_ticks;
				p_target = r.target_ticks;
				p_want = r.pin_action_req;
				p_irq = 1'b1;
				try_arm(r.now_ticks);
				p_cmp = r.target_ticks[CMP_W-1:0];
				ok = 1'b1;
				if (target_passed(r.now_ticks) && !r.match_flag) begin
					p_driven = p_saved;
					p_state = STATUS_MISSED;
					ok = 1'b0;
					note = 1'b1;
				end
			end
			OP_CANCEL: begin
				if (p_state == STATUS_WAIT) begin
					p_irq = 1'b0;
					p_driven = p_saved;
					p_state = STATUS_IDLE;
					ok = 1'b1;
				end else if (p_state == STATUS_ARMED) begin
					dec = r.now_ticks - 32'd1;
					p_cmp = dec[CMP_W-1:0];
					p_irq = 1'b0;
					p_driven = p_saved;
					p_state = STATUS_IDLE;
					ok = !r.match_flag;
				end
			end
			OP_IRQ_EVENT: begin
				if (p_irq) begin
					if (target_passed(r.now_ticks)) begin
						p_irq = 1'b0;
						p_state = (p_state == STATUS_WAIT) ? STATUS_MISSED : STATUS_IDLE;
						note = 1'b1;
					end else begin
						try_arm(r.now_ticks);
					end
				end
			end
			default: ;
		endcase
		res.status = p_state;
		res.success = ok;
		res.pin_action = p_driven;
		res.compare_value = p_cmp;
		res.irq_enable = p_irq;
		res.notify = note;
		return res;
	endfunction

	// Print one line per mismatch and count it.
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("ERROR: response %0d %s: got 0x%0h, expected 0x%0h",
				n_results, what, got, want);
	endtask

	task automatic queue_request(logic [1:0] op, logic [31:0] now, logic [31:0] tgt,
			logic [31:0] org, logic from_now, logic [1:0] act, logic match);
		req_t it;
		it.operation = op;
		it.now_ticks = now;
		it.target_ticks = tgt;
		it.origin_ticks = org;
		it.origin_from_now = from_now;
		it.pin_action_req = act;
		it.match_flag = match;
		sched_requests_q.push_back(it);
	endtask

	// Mostly schedule requests followed by events at advancing times, plus some noise.
	task automatic queue_random_items(int count);
		int made;
		logic [31:0] now;
		logic [31:0] tgt;
		logic [31:0] org;
		logic [1:0] op;
		made = 0;
		while (made < count) begin
			if ($urandom_range(99) < 80) begin
				now = $urandom;
				case ($urandom_range(3))
					0: tgt = now + {15'b0, cfg_window} + $urandom_range(2) - 32'd1;
					1: tgt = now + $urandom_range(150000);
					2: tgt = now - $urandom_range(1, 9000);
					default: tgt = $urandom;
				endcase
				org = ($urandom_range(4) == 0) ? $urandom : now - $urandom_range(9000);
				queue_request(OP_SCHEDULE, now, tgt, org, 1'($urandom_range(1)),
					2'($urandom_range(3)), $urandom_range(9) == 0);
				made++;
				repeat ($urandom_range(4)) begin
					now = now + (($urandom_range(3) == 0) ? $urandom_range(150000)
						: $urandom_range(40000));
					op = ($urandom_range(4) == 0) ? OP_CANCEL : OP_IRQ_EVENT;
					queue_request(op, now, $urandom, $urandom, 1'($urandom_range(1)),
						2'($urandom_range(3)), 1'($urandom_range(1)));
					made++;
				end
			end else begin
				op = 2'($urandom_range(3));
				queue_request(op, $urandom, $urandom, $urandom, 1'($urandom_range(1)),
					2'($urandom_range(3)), 1'($urandom_range(1)));
				if (op != OP_UNUSED)
					made++;
			end
		end
	endtask

	// Register write on the configuration port, with a setup phase and an access phase.
	task automatic write_register(logic [APB_ADDR_W-1:0] addr, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Request driver: presents the next request once the previous one is taken.
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			if (sched_requests_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				req_data <= sched_requests_q.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
		rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Monitor: checks responses in order and predicts each accepted request.
	always @(posedge clk) begin
		rsp_t got;
		rsp_t want;
		req_taken = req_valid && req_ready;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				got = rsp_data;
				n_results++;
				if (sched_results_q.size() == 0) begin
					report_mismatch("unexpected response", 32'(got), 32'd0);
				end else begin
					want = sched_results_q.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", 32'(got.status), 32'(want.status));
					if (got.success !== want.success)
						report_mismatch("success", 32'(got.success), 32'(want.success));
					if (got.pin_action !== want.pin_action)
						report_mismatch("pin_action", 32'(got.pin_action),
							32'(want.pin_action));
					if (got.compare_value !== want.compare_value)
						report_mismatch("compare_value", 32'(got.compare_value),
							32'(want.compare_value));
					if (got.irq_enable !== want.irq_enable)
						report_mismatch("irq_enable", 32'(got.irq_enable),
							32'(want.irq_enable));
					if (got.notify !== want.notify)
						report_mismatch("notify", 32'(got.notify), 32'(want.notify));
					if (want.status == STATUS_ARMED)
						n_armed++;
					if (want.status == STATUS_MISSED)
						n_missed++;
					if (want.notify)
						n_notify++;
				end
			end
			if (req_taken) begin
				n_requests++;
				sched_results_q.push_back(compute_compare_response(req_data));
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles with %0d responses outstanding.",
				cycles, sched_results_q.size());
			$display("extended_compare_action_scheduler_unit regression: fail");
			$finish;
		end
	end

	// Stimulus sequence: reset, directed cases, then phases of random traffic.
	initial begin
		logic [WINDOW_W-1:0] win;
		logic [BACKDATE_W-1:0] bd;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph < 2) begin
				send_idle_pct = 6;
				recv_idle_pct = 58;
			end else if (ph < 4) begin
				send_idle_pct = 58;
				recv_idle_pct = 6;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			if (ph == 0) begin
				// Ignored event, cancel in idle, and the unused operation code.
				queue_request(OP_IRQ_EVENT, 32'h0000_1000, 32'h0000_2000, '0, 1'b0,
					ACT_TOGGLE, 1'b0);
				queue_request(OP_CANCEL, 32'h0000_1000, '0, '0, 1'b0, ACT_DISCONNECT, 1'b0);
				queue_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
					ACT_SET, 1'b1);
				// A near target arms at once, an event re-arms it, then a clean cancel.
				queue_request(OP_SCHEDULE, 32'h0001_0000, 32'h0001_0064, '0, 1'b1,
					ACT_SET, 1'b0);
				queue_request(OP_IRQ_EVENT, 32'h0001_0010, '0, '0, 1'b0, ACT_DISCONNECT, 1'b0);
				queue_request(OP_CANCEL, 32'h0001_0020, '0, '0, 1'b0, ACT_DISCONNECT, 1'b0);
				// A far target waits and is cancelled while waiting.
				queue_request(OP_SCHEDULE, 32'h0002_0000, 32'h0003_86A0, '0, 1'b1,
					ACT_CLEAR, 1'b0);
				queue_request(OP_CANCEL, 32'h0002_0100, '0, '0, 1'b0, ACT_DISCONNECT, 1'b0);
				// A past target without a match is a miss; the next event goes idle.
				queue_request(OP_SCHEDULE, 32'h0003_0000, 32'h0002_FFF6, '0, 1'b1,
					ACT_TOGGLE, 1'b0);
				queue_request(OP_IRQ_EVENT, 32'h0003_0010, '0, '0, 1'b0, ACT_DISCONNECT, 1'b0);
				// A past target with the match flag waits; the event then reports a miss.
				queue_request(OP_SCHEDULE, 32'h0004_0000, 32'h0003_FFF6, '0, 1'b1,
					ACT_TOGGLE, 1'b1);
				queue_request(OP_IRQ_EVENT, 32'h0004_0001, '0, '0, 1'b0, ACT_DISCONNECT, 1'b0);
				queue_request(OP_CANCEL, 32'h0004_0002, '0, '0, 1'b0, ACT_DISCONNECT, 1'b0);
				// Armed with an explicit origin, then cancelled after the match.
				queue_request(OP_SCHEDULE, 32'h0005_0000, 32'h0005_01F4, 32'h0004_FFFF, 1'b0,
					ACT_CLEAR, 1'b0);
				queue_request(OP_CANCEL, 32'h0005_0100, '0, '0, 1'b0, ACT_DISCONNECT, 1'b1);
				// Waiting, armed by a later event, then completed by one past the target.
				queue_request(OP_SCHEDULE, 32'h0006_0000, 32'h0006_9C40, '0, 1'b1,
					ACT_TOGGLE, 1'b0);
				queue_request(OP_IRQ_EVENT, 32'h0006_4E20, '0, '0, 1'b0, ACT_DISCONNECT, 1'b0);
				queue_request(OP_IRQ_EVENT, 32'h0006_9C45, '0, '0, 1'b0, ACT_DISCONNECT, 1'b0);
				// Wrap-around extremes.
				queue_request(OP_SCHEDULE, 32'hFFFF_FFF0, 32'h0000_0010, 32'hFFFF_FF00, 1'b0,
					ACT_SET, 1'b0);
				queue_request(OP_CANCEL, 32'h0000_0000, '0, '0, 1'b0, ACT_DISCONNECT, 1'b0);
				queue_request(OP_SCHEDULE, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
					ACT_DISCONNECT, 1'b0);
				queue_request(OP_SCHEDULE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0,
					ACT_SET, 1'b1);
				queue_request(OP_IRQ_EVENT, 32'hFFFF_FFFF, '0, '0, 1'b0, ACT_DISCONNECT, 1'b0);
			end else begin
				// New limits: the extremes first, a window of one with no backdate, a zero window, then random values.
				case (ph)
					1: begin
						win = 17'd65536;
						bd = 14'd8192;
					end
					2: begin
						win = 17'd1;
						bd = 14'd0;
					end
					3: begin
						win = 17'd0;
						bd = 14'($urandom_range(8192));
					end
					default: begin
						win = 17'($urandom_range(1, 65536));
						bd = 14'($urandom_range(8192));
					end
				endcase
				write_register({REG_WINDOW, 2'b00}, {15'b0, win});
				cfg_window = win;
				write_register({REG_BACKDATE, 2'b00}, {18'b0, bd});
				cfg_backdate = bd;
			end

			queue_random_items(RANDOM_PER_PHASE);

			// Drain before the limits may change again.
			while (sched_requests_q.size() != 0 || req_valid || sched_results_q.size() != 0)
				@(posedge clk);
		end

		repeat (8) @(posedge clk);
		$display("Ran %0d requests and %0d responses over %0d register settings.",
			n_requests, n_results, NUM_PHASES);
		$display("Responses seen: %0d armed, %0d missed, %0d notifications, %0d mismatches.",
			n_armed, n_missed, n_notify, mismatches);
		if (mismatches == 0 && sched_results_q.size() == 0) begin
			$display("extended_compare_action_scheduler_unit regression: pass");
		end else begin
			$display("extended_compare_action_scheduler_unit regression: fail");
		end
		$finish;
	end

endmodule
